// ===== rtl/dfpu_pkg.sv =====
// ----------------------------------------------------------------------------
// dfpu_pkg
// Shared types and constants of the dual fringe phase unwrapper.
// ----------------------------------------------------------------------------
package dfpu_pkg;

   localparam int CORDIC_ITERS = 30;
   localparam int ANGLE_Q      = 30;
   localparam int XY_W         = 48;
   localparam int Z_W          = 33;
   localparam int SQRT3_Q16    = 113512;

   localparam logic [2:0] STEP_THREE = 3'd3;

   typedef enum logic {
      CSR_STEP_COUNT   = 1'b0,
      CSR_PHASE_FACTOR = 1'b1
   } csr_index_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:  v = 33'sd268435456;
         5'd1:  v = 33'sd158466703;
         5'd2:  v = 33'sd83729454;
         5'd3:  v = 33'sd42502378;
         5'd4:  v = 33'sd21333666;
         5'd5:  v = 33'sd10677233;
         5'd6:  v = 33'sd5339919;
         5'd7:  v = 33'sd2670123;
         5'd8:  v = 33'sd1335082;
         5'd9:  v = 33'sd667543;
         5'd10: v = 33'sd333772;
         5'd11: v = 33'sd166886;
         5'd12: v = 33'sd83443;
         5'd13: v = 33'sd41722;
         5'd14: v = 33'sd20861;
         5'd15: v = 33'sd10430;
         5'd16: v = 33'sd5215;
         5'd17: v = 33'sd2608;
         5'd18: v = 33'sd1304;
         5'd19: v = 33'sd652;
         5'd20: v = 33'sd326;
         5'd21: v = 33'sd163;
         5'd22: v = 33'sd81;
         5'd23: v = 33'sd41;
         5'd24: v = 33'sd20;
         5'd25: v = 33'sd10;
         5'd26: v = 33'sd5;
         5'd27: v = 33'sd3;
         5'd28: v = 33'sd1;
         5'd29: v = 33'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/dfpu_cordic.sv =====
// ----------------------------------------------------------------------------
// dfpu_cordic
// Pipelined vectoring cordic, one iteration per stage, angle in units of pi.
// ----------------------------------------------------------------------------
module dfpu_cordic
   import dfpu_pkg::*;
#(
   parameter int PHASE_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         enable,
   input  logic signed [XY_W-1:0]       x_in,
   input  logic signed [XY_W-1:0]       y_in,
   output logic signed [PHASE_FRAC_BITS+1:0] angle
);

   logic signed [XY_W-1:0] x_ff [CORDIC_ITERS+1];
   logic signed [XY_W-1:0] y_ff [CORDIC_ITERS+1];
   logic signed [Z_W-1:0]  z_ff [CORDIC_ITERS+1];
   logic                   zero_ff [CORDIC_ITERS+1];
   logic signed [XY_W-1:0] x0_in, y0_in;
   logic signed [Z_W-1:0]  z0_in;
   logic signed [Z_W-1:0]  zr;

   always_comb begin
      x0_in = x_in;
      y0_in = y_in;
      z0_in = '0;
      if (x_in < 0) begin
         x0_in = -x_in;
         y0_in = -y_in;
         z0_in = (y_in >= 0) ? Z_W'(1 <<< ANGLE_Q) : -Z_W'(1 <<< ANGLE_Q);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (x_in == 0) && (y_in == 0);
         for (int i = 0; i < CORDIC_ITERS; i++) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(5'(i));
            end
         end
      end
   end

   assign zr = (z_ff[CORDIC_ITERS] + Z_W'(1 <<< (ANGLE_Q - 1 - PHASE_FRAC_BITS)))
               >>> (ANGLE_Q - PHASE_FRAC_BITS);
   assign angle = zero_ff[CORDIC_ITERS] ? '0 : zr[PHASE_FRAC_BITS+1:0];

endmodule

// ===== rtl/dual_fringe_phase_unwrap.sv =====
// ----------------------------------------------------------------------------
// dual_fringe_phase_unwrap
// Two-frequency temporal phase unwrapping, one pixel per cycle when not stalled.
//
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_fine_sample_*, req_coarse_sample_*
//  rsp     | out       | rsp_valid, rsp_ready, rsp_absolute_phase, rsp_fringe_order
//  csr     | in        | csr_write, csr_index, csr_data
//
// one pixel per cycle when not stalled; stages: sum and cordic entry stages, the 30
// cordic stages, then difference, multiply, subtract, magnitude, rounding and output
// a stall freezes the whole pipeline; req_ready follows rsp_ready or an empty output
// reset clears valid bits and loads the config registers with defaults, no clearing pass
// ----------------------------------------------------------------------------
module dual_fringe_phase_unwrap
   import dfpu_pkg::*;
#(
   parameter int MAX_STEPS       = 4,
   parameter int PHASE_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_fine_sample_0,
   input  logic [7:0]         req_fine_sample_1,
   input  logic [7:0]         req_fine_sample_2,
   input  logic [7:0]         req_fine_sample_3,
   input  logic [7:0]         req_coarse_sample_0,
   input  logic [7:0]         req_coarse_sample_1,
   input  logic [7:0]         req_coarse_sample_2,
   input  logic [7:0]         req_coarse_sample_3,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [25:0] rsp_absolute_phase,
   output logic signed [8:0]  rsp_fringe_order,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [23:0]        csr_data
);

   localparam int PW    = PHASE_FRAC_BITS + 2;
   localparam int LAT   = CORDIC_ITERS + 8;
   localparam int NUM_W = PHASE_FRAC_BITS + 44;
   localparam int SH    = PHASE_FRAC_BITS + 17;
   localparam int ORD_W = NUM_W - SH + 1;

   logic [2:0]  step_count_ff;
   logic [23:0] phase_factor_ff;
   logic        three;
   logic        enable;
   logic [LAT-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff   <= 3'd4;
         phase_factor_ff <= 24'd131072;
      end else if (csr_write) begin
         case (csr_index)
            CSR_STEP_COUNT:   step_count_ff   <= csr_data[2:0];
            CSR_PHASE_FACTOR: phase_factor_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign three     = (step_count_ff == STEP_THREE) || (MAX_STEPS < 4);
   assign enable    = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = enable;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (enable) valid_ff <= {valid_ff[LAT-2:0], req_valid};
   end

   // stage 0: sums
   logic signed [10:0] fy_ff, fx_ff, cy_ff, cx_ff;
   logic               three_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         three_ff <= three;
         if (three) begin
            fy_ff <= 11'(signed'({3'b0, req_fine_sample_1}))
                     - 11'(signed'({3'b0, req_fine_sample_2}));
            fx_ff <= 11'(signed'({2'b0, req_fine_sample_0, 1'b0}))
                     - 11'(signed'({3'b0, req_fine_sample_1}))
                     - 11'(signed'({3'b0, req_fine_sample_2}));
            cy_ff <= 11'(signed'({3'b0, req_coarse_sample_1}))
                     - 11'(signed'({3'b0, req_coarse_sample_2}));
            cx_ff <= 11'(signed'({2'b0, req_coarse_sample_0, 1'b0}))
                     - 11'(signed'({3'b0, req_coarse_sample_1}))
                     - 11'(signed'({3'b0, req_coarse_sample_2}));
         end else begin
            fy_ff <= 11'(signed'({3'b0, req_fine_sample_1}))
                     - 11'(signed'({3'b0, req_fine_sample_3}));
            fx_ff <= 11'(signed'({3'b0, req_fine_sample_0}))
                     - 11'(signed'({3'b0, req_fine_sample_2}));
            cy_ff <= 11'(signed'({3'b0, req_coarse_sample_1}))
                     - 11'(signed'({3'b0, req_coarse_sample_3}));
            cx_ff <= 11'(signed'({3'b0, req_coarse_sample_0}))
                     - 11'(signed'({3'b0, req_coarse_sample_2}));
         end
      end
   end

   // scale to 2^32, three-step sine sum times sqrt3
   logic signed [XY_W-1:0] fxs, fys, cxs, cys;
   assign fxs = XY_W'(fx_ff) <<< 32;
   assign cxs = XY_W'(cx_ff) <<< 32;
   assign fys = three_ff ? (XY_W'(fy_ff) * XY_W'(SQRT3_Q16)) <<< 16 : XY_W'(fy_ff) <<< 32;
   assign cys = three_ff ? (XY_W'(cy_ff) * XY_W'(SQRT3_Q16)) <<< 16 : XY_W'(cy_ff) <<< 32;

   logic signed [PW-1:0] fine, coarse;

   dfpu_cordic #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_fine (
      .clock(clock), .enable(enable), .x_in(fxs), .y_in(fys), .angle(fine));
   dfpu_cordic #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_coarse (
      .clock(clock), .enable(enable), .x_in(cxs), .y_in(cys), .angle(coarse));

   // wrap difference
   localparam logic signed [PW+1:0] TWO = (PW+2)'(2) <<< PHASE_FRAC_BITS;
   logic signed [PW+1:0] d0, d1;
   logic signed [PW+1:0] diff_ff;
   logic signed [PW-1:0] fine1_ff, fine2_ff, fine3_ff, fine4_ff;
   always_comb begin
      d0 = (PW+2)'(fine) - (PW+2)'(coarse);
      d1 = (d0 < 0) ? d0 + TWO : d0;
      if (d1 > TWO) d1 = d1 - TWO;
   end

   logic signed [NUM_W-1:0] prod_ff, num_ff, mag_ff;
   logic                    neg_ff;
   logic signed [ORD_W-1:0] order_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff  <= d1;
         fine1_ff <= fine;
         prod_ff  <= NUM_W'(diff_ff) * NUM_W'(signed'({1'b0, phase_factor_ff}));
         fine2_ff <= fine1_ff;
         num_ff   <= prod_ff - (NUM_W'(fine2_ff) <<< 16);
         fine3_ff <= fine2_ff;
         neg_ff   <= num_ff < 0;
         mag_ff   <= (num_ff < 0) ? -num_ff : num_ff;
         fine4_ff <= fine3_ff;
      end
   end

   logic signed [NUM_W-1:0] rnd;
   logic signed [ORD_W-1:0] ordm;
   assign rnd  = (mag_ff + (NUM_W'(1) <<< (SH - 1))) >>> SH;
   assign ordm = neg_ff ? -ORD_W'(rnd) : ORD_W'(rnd);

   logic signed [PW-1:0] fine5_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         order_ff <= ordm;
         fine5_ff <= fine4_ff;
      end
   end

   localparam int UW = ORD_W + PHASE_FRAC_BITS + 3;
   logic signed [UW-1:0] unw;
   logic signed [25:0]   absolute_phase_ff;
   logic signed [8:0]    fringe_order_ff;
   assign unw = (UW'(order_ff) <<< (PHASE_FRAC_BITS + 1)) + UW'(fine5_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         if (unw > UW'(33554431))       absolute_phase_ff <= 26'sh1FFFFFF;
         else if (unw < -UW'(33554432)) absolute_phase_ff <= 26'sh2000000;
         else                           absolute_phase_ff <= unw[25:0];
         if (order_ff > ORD_W'(255))       fringe_order_ff <= 9'sd255;
         else if (order_ff < -ORD_W'(256)) fringe_order_ff <= -9'sd256;
         else                              fringe_order_ff <= order_ff[8:0];
      end
   end

   assign rsp_absolute_phase = absolute_phase_ff;
   assign rsp_fringe_order   = fringe_order_ff;
   assign rsp_valid          = valid_ff[LAT-1];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_absolute_phase))
      else $error("result lost during stall");
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fringe_order >= -9'sd256)
      else $error("order out of range");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline stalled while output empty");

endmodule
